// ===== sv/binary_to_seven_segment_blanking_macros.svh =====
// Assertion macros shared by the seven-segment decoder modules.
// Each macro expects signals named clk and arst_n in the using module.
`ifndef BINARY_TO_SEVEN_SEGMENT_BLANKING_MACROS_SVH
`define BINARY_TO_SEVEN_SEGMENT_BLANKING_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define BSB_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define BSB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/bsb_pkg.sv =====
// Package for the seven-segment decoder: widths, segment codes and digit helpers.
// Used by bsb_split, bsb_encode and binary_to_seven_segment_blanking.
package bsb_pkg;

	localparam int VALUE_W = 16;
	localparam int SEG_W   = 8;
	localparam int CNT_W   = 3;
	localparam int DATA_W  = 32;
	localparam int ADDR_W  = 3;

	localparam logic [CNT_W-1:0] CNT_RESET = 3'd5;
	localparam logic [CNT_W-1:0] CNT_FOUR  = 3'd4;

	// Register index of digit_count.
	localparam logic REG_DIGIT_COUNT = 1'b0;

	localparam logic [SEG_W-1:0] SEG_BLANK = 8'hff;

	localparam int TEN_THOUSAND = 10000;
	localparam int THOUSAND     = 1000;
	localparam int HUNDRED      = 100;
	localparam int TEN          = 10;

	// Decimal digits of one word, top digit first.
	typedef struct packed {
		logic       four;
		logic [2:0] d4;
		logic [3:0] d3;
		logic [3:0] d2;
		logic [3:0] d1;
		logic [3:0] d0;
	} digits_t;

	// Leading digit and remainder of a split by one decimal weight.
	typedef struct packed {
		logic [3:0]         digit;
		logic [VALUE_W-1:0] rest;
	} split_t;

	// Finds the leading digit by parallel compares against the multiples of the weight.
	function automatic split_t split_digit(input logic [VALUE_W-1:0] x, input int unit);
		split_t r;
		int     d;
		d = 0;
		for (int k = 1; k <= 9; k++) begin
			if (int'(x) >= k * unit) begin
				d = k;
			end
		end
		r.digit = 4'(d);
		r.rest  = VALUE_W'(int'(x) - d * unit);
		return r;
	endfunction

	// Active-low common-anode code of one decimal digit.
	function automatic logic [SEG_W-1:0] seg_code(input logic [3:0] d);
		logic [SEG_W-1:0] s;
		unique case (d)
			4'd0: s = 8'hc0;
			4'd1: s = 8'hf9;
			4'd2: s = 8'ha4;
			4'd3: s = 8'hb0;
			4'd4: s = 8'h99;
			4'd5: s = 8'h92;
			4'd6: s = 8'h82;
			4'd7: s = 8'hf8;
			4'd8: s = 8'h80;
			4'd9: s = 8'h90;
			default: s = SEG_BLANK;
		endcase
		return s;
	endfunction

endpackage

// ===== sv/bsb_split.sv =====
// Digit split pipeline: input register and four digit stages; the last yields two digits.
// Depends on bsb_pkg and the assertion macros header.
`include "binary_to_seven_segment_blanking_macros.svh"

module bsb_split (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        four,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [bsb_pkg::VALUE_W-1:0] value,
	output logic                        out_valid,
	input  logic                        out_stall,
	output bsb_pkg::digits_t            out_digits
);
	import bsb_pkg::*;

	logic               valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic               rdy1, rdy2, rdy3, rdy4, rdy5;
	logic [VALUE_W-1:0] value_s1;
	logic               four_s1, four_s2, four_s3, four_s4, four_s5;
	logic [2:0]         d4_s2, d4_s3, d4_s4, d4_s5;
	logic [13:0]        rest_s2;
	logic [3:0]         d3_s3, d3_s4, d3_s5;
	logic [9:0]         rest_s3;
	logic [3:0]         d2_s4, d2_s5;
	logic [6:0]         rest_s4;
	logic [3:0]         d1_s5, d0_s5;
	split_t             sp2, sp3, sp4, sp5;

	// A stage takes a new word when it is empty or its word moves on.
	assign rdy5     = !valid_s5 || !out_stall;
	assign rdy4     = !valid_s4 || rdy5;
	assign rdy3     = !valid_s3 || rdy4;
	assign rdy2     = !valid_s2 || rdy3;
	assign rdy1     = !valid_s1 || rdy2;
	assign in_stall = !rdy1;

	// Split combinational logic between the stages.
	assign sp2 = split_digit(value_s1, TEN_THOUSAND);
	assign sp3 = split_digit(VALUE_W'(rest_s2), THOUSAND);
	assign sp4 = split_digit(VALUE_W'(rest_s3), HUNDRED);
	assign sp5 = split_digit(VALUE_W'(rest_s4), TEN);

	// Valid bits of all stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (rdy1) valid_s1 <= in_valid;
			if (rdy2) valid_s2 <= valid_s1;
			if (rdy3) valid_s3 <= valid_s2;
			if (rdy4) valid_s4 <= valid_s3;
			if (rdy5) valid_s5 <= valid_s4;
		end
	end

	// Stage 1 holds the accepted word and the mode.
	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) begin
			value_s1 <= value;
			four_s1  <= four;
		end
	end

	// Stage 2 takes off the ten-thousands; four-digit mode keeps only the remainder.
	always_ff @(posedge clk) begin
		if (rdy2 && valid_s1) begin
			four_s2 <= four_s1;
			d4_s2   <= four_s1 ? 3'd0 : sp2.digit[2:0];
			rest_s2 <= sp2.rest[13:0];
		end
	end

	// Stage 3 takes off the thousands.
	always_ff @(posedge clk) begin
		if (rdy3 && valid_s2) begin
			four_s3 <= four_s2;
			d4_s3   <= d4_s2;
			d3_s3   <= sp3.digit;
			rest_s3 <= sp3.rest[9:0];
		end
	end

	// Stage 4 takes off the hundreds.
	always_ff @(posedge clk) begin
		if (rdy4 && valid_s3) begin
			four_s4 <= four_s3;
			d4_s4   <= d4_s3;
			d3_s4   <= d3_s3;
			d2_s4   <= sp4.digit;
			rest_s4 <= sp4.rest[6:0];
		end
	end

	// Stage 5 splits tens and units.
	always_ff @(posedge clk) begin
		if (rdy5 && valid_s4) begin
			four_s5 <= four_s4;
			d4_s5   <= d4_s4;
			d3_s5   <= d3_s4;
			d2_s5   <= d2_s4;
			d1_s5   <= sp5.digit;
			d0_s5   <= sp5.rest[3:0];
		end
	end

	assign out_valid       = valid_s5;
	assign out_digits.four = four_s5;
	assign out_digits.d4   = d4_s5;
	assign out_digits.d3   = d3_s5;
	assign out_digits.d2   = d2_s5;
	assign out_digits.d1   = d1_s5;
	assign out_digits.d0   = d0_s5;

	`BSB_ASSERT_NOW(a_digits_decimal, valid_s5,
		(d3_s5 <= 4'd9) && (d2_s5 <= 4'd9) && (d1_s5 <= 4'd9) && (d0_s5 <= 4'd9),
		"split produced a digit above nine")
	`BSB_ASSERT_NOW(a_four_no_top, valid_s5 && four_s5, d4_s5 == 3'd0,
		"four-digit mode left a nonzero top digit")

endmodule

// ===== sv/bsb_encode.sv =====
// Output stage: segment lookup and leading-zero blanking into the result register.
// Depends on bsb_pkg and the assertion macros header.
`include "binary_to_seven_segment_blanking_macros.svh"

module bsb_encode (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  bsb_pkg::digits_t          digits,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [bsb_pkg::SEG_W-1:0] seg_units,
	output logic [bsb_pkg::SEG_W-1:0] seg_tens,
	output logic [bsb_pkg::SEG_W-1:0] seg_hundreds,
	output logic [bsb_pkg::SEG_W-1:0] seg_thousands,
	output logic [bsb_pkg::SEG_W-1:0] seg_ten_thousands
);
	import bsb_pkg::*;

	logic             valid_s6, rdy6;
	logic             b4, b3, b2, b1;
	logic [SEG_W-1:0] seg0_s6, seg1_s6, seg2_s6, seg3_s6, seg4_s6;

	assign rdy6     = !valid_s6 || !out_stall;
	assign in_stall = !rdy6;

	// Blanking runs from the top digit down and stops at the first nonzero digit.
	assign b4 = (digits.d4 == 3'd0);
	assign b3 = b4 && (digits.d3 == 4'd0);
	assign b2 = b3 && (digits.d2 == 4'd0);
	assign b1 = b2 && (digits.d1 == 4'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s6 <= 1'b0;
		end else if (rdy6) begin
			valid_s6 <= in_valid;
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (rdy6 && in_valid) begin
			seg0_s6 <= seg_code(digits.d0);
			seg1_s6 <= b1 ? SEG_BLANK : seg_code(digits.d1);
			seg2_s6 <= b2 ? SEG_BLANK : seg_code(digits.d2);
			seg3_s6 <= b3 ? SEG_BLANK : seg_code(digits.d3);
			seg4_s6 <= (b4 || digits.four) ? SEG_BLANK : seg_code({1'b0, digits.d4});
		end
	end

	assign out_valid         = valid_s6;
	assign seg_units         = seg0_s6;
	assign seg_tens          = seg1_s6;
	assign seg_hundreds      = seg2_s6;
	assign seg_thousands     = seg3_s6;
	assign seg_ten_thousands = seg4_s6;

	`BSB_ASSERT_NOW(a_units_shown, valid_s6, seg0_s6 != SEG_BLANK,
		"units digit was blanked")
	`BSB_ASSERT_NOW(a_blank_order, valid_s6 && (seg2_s6 != SEG_BLANK),
		(seg1_s6 != SEG_BLANK), "tens blanked below a shown hundreds digit")

endmodule

// ===== sv/binary_to_seven_segment_blanking.sv =====
// Top level of the binary to seven-segment decoder with leading-zero blanking.
// Depends on bsb_pkg, bsb_split, bsb_encode and the assertion macros header.
//
// Usage:
// The input channel (in_valid, in_stall, value) takes one 16-bit word; the
// output channel (out_valid, out_stall, seg_*) returns its five active-low
// segment codes, units first. A word is moved when valid is high and stall low.
// A word passes one input register, four digit stages (one decimal weight each,
// by parallel compares) and the result register. A new word can be taken every
// cycle, so throughput is one word per cycle while the receiver does not stall.
// When it stalls, words wait in the stages; the input stalls only once every
// stage holds a word. Reset empties the pipeline and sets digit_count to five.
// digit_count (APB address 0) selects four-digit mode when written with four;
// the user writes it only while the block is idle; the block does not enforce it.
`include "binary_to_seven_segment_blanking_macros.svh"

module binary_to_seven_segment_blanking (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [bsb_pkg::ADDR_W-1:0]  paddr,
	input  logic [bsb_pkg::DATA_W-1:0]  pwdata,
	output logic [bsb_pkg::DATA_W-1:0]  prdata,
	output logic                        pready,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [bsb_pkg::VALUE_W-1:0] value,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [bsb_pkg::SEG_W-1:0]   seg_units,
	output logic [bsb_pkg::SEG_W-1:0]   seg_tens,
	output logic [bsb_pkg::SEG_W-1:0]   seg_hundreds,
	output logic [bsb_pkg::SEG_W-1:0]   seg_thousands,
	output logic [bsb_pkg::SEG_W-1:0]   seg_ten_thousands
);
	import bsb_pkg::*;

	logic [CNT_W-1:0] digit_count_q;
	logic             four;
	logic             mid_valid, mid_stall;
	digits_t          mid_digits;

	// Register interface: one register, written on the access phase.
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_count_q <= CNT_RESET;
		end else if (psel && penable && pwrite && pready && (paddr[2] == REG_DIGIT_COUNT)) begin
			digit_count_q <= pwdata[CNT_W-1:0];
		end
	end

	assign prdata = (paddr[2] == REG_DIGIT_COUNT) ? DATA_W'(digit_count_q) : '0;

	// Any setting other than four decodes all five digits.
	assign four = (digit_count_q == CNT_FOUR);

	bsb_split u_split (
		.clk        (clk),
		.arst_n     (arst_n),
		.four       (four),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.value      (value),
		.out_valid  (mid_valid),
		.out_stall  (mid_stall),
		.out_digits (mid_digits)
	);

	bsb_encode u_encode (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (mid_valid),
		.in_stall          (mid_stall),
		.digits            (mid_digits),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.seg_units         (seg_units),
		.seg_tens          (seg_tens),
		.seg_hundreds      (seg_hundreds),
		.seg_thousands     (seg_thousands),
		.seg_ten_thousands (seg_ten_thousands)
	);

	`BSB_ASSERT_NOW(a_stall_only_full, in_stall, out_valid && out_stall && mid_valid,
		"input stalled while the pipeline had room")

endmodule

// ===== dv/tb_binary_to_seven_segment_blanking.sv =====
// Testbench for binary_to_seven_segment_blanking: a directed word table, then random words
// under every digit_count setting, with random idling, a long output hold-off and APB read-back.
// Depends on bsb_pkg and the decoder RTL only.
module tb_binary_to_seven_segment_blanking;
	timeunit 1ns;
	timeprecision 1ps;

	import bsb_pkg::*;

	// Five segment codes of one word, units first.
	typedef struct packed {
		logic [SEG_W-1:0] units;
		logic [SEG_W-1:0] tens;
		logic [SEG_W-1:0] hundreds;
		logic [SEG_W-1:0] thousands;
		logic [SEG_W-1:0] ten_thousands;
	} segs_t;

	// One directed word: the mode it runs in, the word, and a typed expectation where obvious.
	typedef struct packed {
		logic [CNT_W-1:0]   mode;
		logic [VALUE_W-1:0] word;
		logic               typed;
		segs_t              want;
	} row_t;

	localparam logic [SEG_W-1:0] SEG_DIGIT [10] = '{
		8'hc0, 8'hf9, 8'ha4, 8'hb0, 8'h99, 8'h92, 8'h82, 8'hf8, 8'h80, 8'h90
	};

	localparam logic [ADDR_W-1:0] ADDR_DIGIT_COUNT = ADDR_W'(4 * REG_DIGIT_COUNT);
	localparam logic [ADDR_W-1:0] ADDR_UNMAPPED    = ADDR_W'(4);

	localparam int PIPE_LATENCY   = 6;
	localparam int SETTLE         = PIPE_LATENCY + 4;
	localparam int HOLD_CYCLES    = 60;
	localparam int RANDOM_WORDS   = 55;
	localparam int PRESSURE_WORDS = 40;
	localparam int CYCLE_LIMIT    = 300000;

	localparam segs_t NO_SEGS       = '0;
	localparam segs_t SEGS_ZERO     = {SEG_DIGIT[0], {4{SEG_BLANK}}};
	localparam segs_t SEGS_TEN_K    = {{4{SEG_DIGIT[0]}}, SEG_DIGIT[1]};
	localparam segs_t SEGS_MAX_FIVE = {SEG_DIGIT[5], SEG_DIGIT[3], SEG_DIGIT[5], SEG_DIGIT[5],
		SEG_DIGIT[6]};
	localparam segs_t SEGS_MAX_FOUR = {SEG_DIGIT[5], SEG_DIGIT[3], SEG_DIGIT[5], SEG_DIGIT[5],
		SEG_BLANK};

	localparam row_t WORD_TABLE [25] = '{
		'{CNT_RESET, 16'd0,     1'b1, SEGS_ZERO},
		'{CNT_RESET, 16'd65535, 1'b1, SEGS_MAX_FIVE},
		'{CNT_RESET, 16'd10000, 1'b1, SEGS_TEN_K},
		'{CNT_RESET, 16'd1,     1'b0, NO_SEGS},
		'{CNT_RESET, 16'd9,     1'b0, NO_SEGS},
		'{CNT_RESET, 16'd10,    1'b0, NO_SEGS},
		'{CNT_RESET, 16'd99,    1'b0, NO_SEGS},
		'{CNT_RESET, 16'd100,   1'b0, NO_SEGS},
		'{CNT_RESET, 16'd1000,  1'b0, NO_SEGS},
		'{CNT_RESET, 16'd9999,  1'b0, NO_SEGS},
		'{CNT_RESET, 16'd10001, 1'b0, NO_SEGS},
		'{CNT_RESET, 16'd12345, 1'b0, NO_SEGS},
		'{CNT_RESET, 16'd6789,  1'b0, NO_SEGS},
		'{CNT_RESET, 16'd40060, 1'b0, NO_SEGS},
		'{CNT_RESET, 16'd32768, 1'b0, NO_SEGS},
		'{CNT_RESET, 16'd21845, 1'b0, NO_SEGS},
		'{CNT_RESET, 16'd43690, 1'b0, NO_SEGS},
		'{CNT_RESET, 16'd60000, 1'b0, NO_SEGS},
		'{CNT_FOUR,  16'd0,     1'b1, SEGS_ZERO},
		'{CNT_FOUR,  16'd65535, 1'b1, SEGS_MAX_FOUR},
		'{CNT_FOUR,  16'd10000, 1'b1, SEGS_ZERO},
		'{CNT_FOUR,  16'd9999,  1'b0, NO_SEGS},
		'{CNT_FOUR,  16'd20000, 1'b0, NO_SEGS},
		'{CNT_FOUR,  16'd10010, 1'b0, NO_SEGS},
		'{CNT_FOUR,  16'd54321, 1'b0, NO_SEGS}
	};

	// digit_count settings of the random phases; everything but four is five-digit mode.
	localparam logic [CNT_W-1:0] MODE_SWEEP [10] = '{
		CNT_FOUR, 3'd0, 3'd7, CNT_RESET, 3'd6, 3'd1, 3'd2, 3'd3, CNT_FOUR, CNT_RESET
	};

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [ADDR_W-1:0]   paddr = '0;
	logic [DATA_W-1:0]   pwdata = '0;
	logic [DATA_W-1:0]   prdata;
	logic                pready;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic [VALUE_W-1:0]  value = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [SEG_W-1:0]    seg_units;
	logic [SEG_W-1:0]    seg_tens;
	logic [SEG_W-1:0]    seg_hundreds;
	logic [SEG_W-1:0]    seg_thousands;
	logic [SEG_W-1:0]    seg_ten_thousands;

	logic [CNT_W-1:0] digit_count_model = CNT_RESET;
	segs_t            pending_segs [$];
	segs_t            got_segs;
	segs_t            want_segs;
	bit               idle_on = 1'b1;
	bit               hold_req = 1'b0;
	bit               hold_seen = 1'b0;
	int               stall_left = 0;
	int               hold_left = 0;
	int               errors = 0;
	int               words = 0;
	int               results = 0;
	int               writes = 0;
	int               input_stall_cycles = 0;
	int               cycles = 0;

	binary_to_seven_segment_blanking DUT (
		.clk              (clk),
		.arst_n           (arst_n),
		.psel             (psel),
		.penable          (penable),
		.pwrite           (pwrite),
		.paddr            (paddr),
		.pwdata           (pwdata),
		.prdata           (prdata),
		.pready           (pready),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.value            (value),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.seg_units        (seg_units),
		.seg_tens         (seg_tens),
		.seg_hundreds     (seg_hundreds),
		.seg_thousands    (seg_thousands),
		.seg_ten_thousands(seg_ten_thousands)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// Expected codes: decimal digits with leading zeros above units blanked; mode four blanks the top.
	function automatic segs_t decode_word(input logic [VALUE_W-1:0] w,
		input logic [CNT_W-1:0] mode);
		int               n;
		int               dig [5];
		logic [SEG_W-1:0] code [5];
		bit               leading;
		n = int'(w);
		if (mode == CNT_FOUR) begin
			n = n % TEN_THOUSAND;
		end
		for (int i = 0; i < 5; i++) begin
			dig[i] = n % 10;
			n = n / 10;
		end
		leading = 1'b1;
		for (int i = 4; i >= 1; i--) begin
			if (leading && dig[i] == 0) begin
				code[i] = SEG_BLANK;
			end else begin
				leading = 1'b0;
				code[i] = SEG_DIGIT[dig[i]];
			end
		end
		code[0] = SEG_DIGIT[dig[0]];
		if (mode == CNT_FOUR) begin
			code[4] = SEG_BLANK;
		end
		return {code[0], code[1], code[2], code[3], code[4]};
	endfunction

	// Random word: full range, small values, near multiples of powers of ten, or digits with many zeros.
	function automatic logic [VALUE_W-1:0] pick_word();
		int n;
		int p;
		case ($urandom_range(0, 5))
			0, 1: n = $urandom_range(0, 65535);
			2: n = $urandom_range(0, 99);
			3: n = $urandom_range(0, 9999);
			4: begin
				p = 10 ** $urandom_range(1, 4);
				n = p * $urandom_range(1, 6) + $urandom_range(0, 2) - 1;
			end
			default: begin
				n = 0;
				p = 1;
				for (int k = 0; k < 5; k++) begin
					if ($urandom_range(0, 1) == 1) begin
						n += p * $urandom_range(1, 9);
					end
					p *= 10;
				end
			end
		endcase
		return VALUE_W'(n);
	endfunction

	// Sender gap: none when idling is off, else mostly none, some short, a few long.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (!idle_on || r < 60) begin
			return 0;
		end else if (r < 90) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 25);
	endfunction

	task automatic flag_mismatch(input string msg);
		errors++;
		if (errors <= 10) begin
			$display("mismatch: %s", msg);
		end
	endtask

	// APB write: setup cycle, then access until pready.
	task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		writes++;
		@(posedge clk);
	endtask

	task automatic apb_read(input logic [ADDR_W-1:0] addr, output logic [DATA_W-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= addr;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		data = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic check_digit_count();
		logic [DATA_W-1:0] rd;
		apb_read(ADDR_DIGIT_COUNT, rd);
		if (rd !== DATA_W'(digit_count_model)) begin
			flag_mismatch($sformatf("digit_count read back %h, expected %h", rd,
				DATA_W'(digit_count_model)));
		end
	endtask

	// Only the low bits of the word land in the register; the upper bits are random noise.
	task automatic set_digit_count(input logic [CNT_W-1:0] mode);
		logic [DATA_W-1:0] data;
		data = $urandom();
		data[CNT_W-1:0] = mode;
		apb_write(ADDR_DIGIT_COUNT, data);
		digit_count_model = mode;
		check_digit_count();
	endtask

	task automatic wait_idle();
		while (pending_segs.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Offer one word, hold it until accepted, then record its expected codes.
	task automatic send_word(input logic [VALUE_W-1:0] w, input logic typed, input segs_t want,
		input int gap);
		in_valid <= 1'b1;
		value <= w;
		do @(posedge clk); while (in_stall);
		pending_segs.push_back(typed ? want : decode_word(w, digit_count_model));
		words++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic end_burst();
		in_valid <= 1'b0;
		wait_idle();
	endtask

	// Result checker and output stall pattern, including the long hold-off on request.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			results++;
			got_segs = {seg_units, seg_tens, seg_hundreds, seg_thousands, seg_ten_thousands};
			if (pending_segs.size() == 0) begin
				flag_mismatch($sformatf("codes %h arrived with no word outstanding", got_segs));
			end else begin
				want_segs = pending_segs.pop_front();
				if (got_segs !== want_segs) begin
					flag_mismatch($sformatf({"units %h/%h tens %h/%h hundreds %h/%h ",
						"thousands %h/%h ten_thousands %h/%h (got/expected)"},
						got_segs.units, want_segs.units, got_segs.tens, want_segs.tens,
						got_segs.hundreds, want_segs.hundreds, got_segs.thousands,
						want_segs.thousands, got_segs.ten_thousands, want_segs.ten_thousands));
				end
			end
		end
		if (hold_req && !hold_seen) begin
			hold_left = HOLD_CYCLES;
		end
		hold_seen = hold_req;
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else if (idle_on && $urandom_range(0, 3) == 0) begin
			out_stall <= 1'b1;
			stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
				: $urandom_range(0, 2);
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Cycle count, input back-pressure count and the run limit.
	always @(posedge clk) begin
		cycles++;
		if (in_valid && in_stall) begin
			input_stall_cycles++;
		end
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles with %0d results outstanding", cycles,
				pending_segs.size());
			$display("FAIL binary_to_seven_segment_blanking");
			$finish;
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		check_digit_count();

		// Directed words; a mode change waits for the pipeline to drain.
		foreach (WORD_TABLE[i]) begin
			if (WORD_TABLE[i].mode != digit_count_model) begin
				end_burst();
				set_digit_count(WORD_TABLE[i].mode);
			end
			send_word(WORD_TABLE[i].word, WORD_TABLE[i].typed, WORD_TABLE[i].want,
				pick_gap());
		end
		end_burst();

		// Random words under each setting; some phases run with no idling at all.
		foreach (MODE_SWEEP[ph]) begin
			set_digit_count(MODE_SWEEP[ph]);
			if (ph == 3) begin
				// A write past the last register must leave digit_count alone.
				apb_write(ADDR_UNMAPPED, DATA_W'(CNT_FOUR));
				check_digit_count();
			end
			idle_on <= (ph % 4 != 2);
			repeat (RANDOM_WORDS) send_word(pick_word(), 1'b0, NO_SEGS, pick_gap());
			end_burst();
		end

		// Back-to-back words against a long output hold-off, so the input stalls.
		idle_on <= 1'b0;
		hold_req <= 1'b1;
		repeat (PRESSURE_WORDS) send_word(pick_word(), 1'b0, NO_SEGS, 0);
		hold_req <= 1'b0;
		end_burst();

		$display("Run sent %0d words, checked %0d results, %0d register writes, settings 0 to 7.",
			words, results, writes);
		$display("Input held back %0d cycles under output hold-off; %0d mismatches.",
			input_stall_cycles, errors);
		if (errors == 0) begin
			$display("PASS binary_to_seven_segment_blanking");
		end else begin
			$display("FAIL binary_to_seven_segment_blanking");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/bsb_pkg.sv
sv/bsb_split.sv
sv/bsb_encode.sv
sv/binary_to_seven_segment_blanking.sv
dv/tb_binary_to_seven_segment_blanking.sv
